[hw/rtl/ubh_pkg.sv]
// Shared widths, register map and state encoding for the uniform-bin histogram.
// Used by uniform_bin_histogram_unit, its checker and the testbench; depends on nothing else.
`timescale 1ns / 1ps

package ubh_pkg;

    localparam int MAX_BINS   = 256;
    localparam int BIN_W      = $clog2(MAX_BINS);
    localparam int SAMPLE_W   = 32;
    localparam int COUNT_W    = 32;
    localparam int EDGE_W     = 32;
    localparam int NBINS_W    = 9;
    localparam int INV_W      = 32;
    localparam int PROD_W     = SAMPLE_W + INV_W;
    localparam int IN_DATA_W  = ((SAMPLE_W + BIN_W + 7) / 8) * 8;
    localparam int OUT_DATA_W = ((COUNT_W + BIN_W + 7) / 8) * 8;
    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    typedef enum logic [1:0] {
        REG_EDGE_MIN  = 2'd0,
        REG_EDGE_MAX  = 2'd1,
        REG_NUM_BINS  = 2'd2,
        REG_INV_WIDTH = 2'd3
    } cfg_idx_t;

    typedef enum logic [0:0] {
        REQ_ADD  = 1'b0,
        REQ_READ = 1'b1
    } req_t;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_MUL  = 4'b0010,
        S_ADDR = 4'b0100,
        S_UPD  = 4'b1000
    } state_t;

endpackage

[hw/rtl/uniform_bin_histogram_unit.sv]
// Uniform-bin histogram: count memory with read-modify-write and APB registers.
// Depends on ubh_pkg for widths, register indexes and the state encoding.
// An add beat that lands in a bin steps through accept, multiply, memory read and write back;
// one outside the range skips write back, and a read beat skips multiply. A read result
// is registered from write back, where a read waits while the result register is still full.
// Reset is asynchronous and active low; it loads the register defaults and clears all bins
// at once through per-bin valid bits, so no clearing pass is needed.
`timescale 1ns / 1ps

module uniform_bin_histogram_unit (
    input  logic                              clk,
    input  logic                              rst_n,
    // APB configuration port
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [ubh_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [ubh_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [ubh_pkg::APB_DATA_W-1:0]    prdata,
    output logic                              pready,
    // Request stream
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [ubh_pkg::IN_DATA_W-1:0]     s_tdata,   // sample_value[31:0], bin_select[39:32]
    input  logic                              s_tuser,   // req_type
    // Result stream
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [ubh_pkg::OUT_DATA_W-1:0]    m_tdata    // bin_count[31:0], bin_index[39:32]
);

    import ubh_pkg::*;

    state_t state_reg, state_next;

    logic [EDGE_W-1:0]  edge_min_reg;
    logic [EDGE_W-1:0]  edge_max_reg;
    logic [NBINS_W-1:0] num_bins_reg;
    logic [INV_W-1:0]   inv_width_reg;

    logic               req_read_reg;
    logic               hit_reg;
    logic               last_reg;
    logic [SAMPLE_W-1:0] diff_reg;
    logic [BIN_W-1:0]   sel_reg;
    logic [PROD_W-1:0]  prod_reg;
    logic [BIN_W-1:0]   addr_reg;
    logic               valid_hit_reg;
    logic [COUNT_W-1:0] rd_data_reg;
    logic [MAX_BINS-1:0] valid_reg;
    logic [COUNT_W-1:0] mem [MAX_BINS];

    logic                  m_valid_reg;
    logic [OUT_DATA_W-1:0] m_data_reg;

    logic               cfg_we;
    logic               in_accept;
    logic signed [SAMPLE_W-1:0] sample;
    logic signed [EDGE_W-1:0]   lo_s;
    logic signed [EDGE_W-1:0]   hi_s;
    logic [SAMPLE_W:0]  diff_full;
    logic               in_range;
    logic               at_max;
    logic [BIN_W-1:0]   nb_m1;
    logic [BIN_W-1:0]   bin_clamped;
    logic [BIN_W-1:0]   rd_addr;
    logic [COUNT_W-1:0] cur_count;
    logic               out_free;
    logic               mem_we;
    logic [COUNT_W-1:0] mem_wdata;

    assign pready    = 1'b1;
    assign cfg_we    = psel & penable & pwrite & pready;
    assign s_tready  = (state_reg == S_IDLE);
    assign in_accept = s_tvalid & s_tready;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = m_data_reg;

    always_comb
    begin
        unique case (cfg_idx_t'(paddr[3:2]))
            REG_EDGE_MIN:  prdata = edge_min_reg;
            REG_EDGE_MAX:  prdata = edge_max_reg;
            REG_NUM_BINS:  prdata = {{(APB_DATA_W-NBINS_W){1'b0}}, num_bins_reg};
            REG_INV_WIDTH: prdata = inv_width_reg;
            default:       prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            edge_min_reg  <= '0;
            edge_max_reg  <= EDGE_W'(32'd16777216);
            num_bins_reg  <= NBINS_W'(MAX_BINS);
            inv_width_reg <= INV_W'(32'd65536);
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx_t'(paddr[3:2]))
                REG_EDGE_MIN:  edge_min_reg  <= pwdata[EDGE_W-1:0];
                REG_EDGE_MAX:  edge_max_reg  <= pwdata[EDGE_W-1:0];
                REG_NUM_BINS:  num_bins_reg  <= pwdata[NBINS_W-1:0];
                REG_INV_WIDTH: inv_width_reg <= pwdata[INV_W-1:0];
                default:       ;
            endcase
        end
    end

    // Range test and offset from the lower edge, taken straight off the input beat.
    always_comb
    begin
        sample    = $signed(s_tdata[SAMPLE_W-1:0]);
        lo_s      = $signed(edge_min_reg);
        hi_s      = $signed(edge_max_reg);
        diff_full = {sample[SAMPLE_W-1], sample} - {lo_s[EDGE_W-1], lo_s};
        in_range  = (sample >= lo_s) && (sample < hi_s);
        at_max    = (sample == hi_s);
    end

    // Last bin in use; a zero bin count acts as one bin, a large one as the whole store.
    always_comb
    begin
        if (num_bins_reg == '0)
            nb_m1 = '0;
        else if (num_bins_reg >= NBINS_W'(MAX_BINS))
            nb_m1 = BIN_W'(MAX_BINS - 1);
        else
            nb_m1 = BIN_W'(num_bins_reg - NBINS_W'(1));
    end

    always_comb
    begin
        if (last_reg || (prod_reg[PROD_W-1:INV_W] > {{(PROD_W-INV_W-BIN_W){1'b0}}, nb_m1}))
            bin_clamped = nb_m1;
        else
            bin_clamped = prod_reg[INV_W+BIN_W-1:INV_W];
        rd_addr = req_read_reg ? sel_reg : bin_clamped;
    end

    always_comb
    begin
        cur_count = valid_hit_reg ? rd_data_reg : '0;
        out_free  = !m_valid_reg || m_tready;
        mem_we    = (state_reg == S_UPD) && (!req_read_reg || out_free);
        if (req_read_reg)
            mem_wdata = '0;
        else if (&cur_count)
            mem_wdata = cur_count;
        else
            mem_wdata = cur_count + COUNT_W'(1);
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                    state_next = (req_t'(s_tuser) == REQ_READ) ? S_ADDR : S_MUL;
            end
            S_MUL:  state_next = S_ADDR;
            S_ADDR: state_next = (req_read_reg || hit_reg) ? S_UPD : S_IDLE;
            S_UPD:
            begin
                if (mem_we)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            req_read_reg <= (req_t'(s_tuser) == REQ_READ);
            hit_reg      <= in_range || at_max;
            last_reg     <= at_max && !in_range;
            diff_reg     <= diff_full[SAMPLE_W-1:0];
            sel_reg      <= s_tdata[SAMPLE_W+BIN_W-1:SAMPLE_W];
        end
        if (state_reg == S_MUL)
            prod_reg <= PROD_W'(diff_reg) * PROD_W'(inv_width_reg);
        if (state_reg == S_ADDR)
        begin
            addr_reg      <= rd_addr;
            valid_hit_reg <= valid_reg[rd_addr];
        end
    end

    // Count memory: one read port, one write port, registered read data.
    always_ff @(posedge clk)
    begin
        if (state_reg == S_ADDR)
            rd_data_reg <= mem[rd_addr];
        if (mem_we)
            mem[addr_reg] <= mem_wdata;
    end

    // A bin whose valid bit is low reads as zero.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else if (mem_we)
            valid_reg[addr_reg] <= 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_valid_reg <= 1'b0;
        else if (mem_we && req_read_reg)
            m_valid_reg <= 1'b1;
        else if (m_tready)
            m_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we && req_read_reg)
            m_data_reg <= OUT_DATA_W'({addr_reg, cur_count});
    end

    a_result_from_read: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_valid_reg) |-> $past(state_reg == S_UPD && req_read_reg))
        else $error("result raised without a read request");

    a_written_bin_valid: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |=> valid_reg[$past(addr_reg)])
        else $error("written bin not marked valid");

    a_add_bin_in_use: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ADDR && !req_read_reg && hit_reg) |-> (rd_addr <= nb_m1))
        else $error("add beat addresses a bin past the last in use");

    a_no_accept_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_UPD && !mem_we) |=> (state_reg == S_UPD))
        else $error("update left before write back");

endmodule

[tb/uniform_bin_histogram_checker.sv]
// Checker for uniform_bin_histogram_unit: mirrors the registers and the bin counts,
// predicts every read-and-clear result and compares it with the result stream.
// Depends on ubh_pkg for widths, register indexes and request kinds.
`timescale 1ns / 1ps

module uniform_bin_histogram_checker
    import ubh_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    input  logic                  pready,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,   // sample_value[31:0], bin_select[39:32]
    input  logic                  s_tuser,   // req_type
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [OUT_DATA_W-1:0] m_tdata,   // bin_count[31:0], bin_index[39:32]
    output int                    mismatch_total,
    output int                    reads_waiting
);

    typedef struct packed {
        logic [COUNT_W-1:0] count;
        logic [BIN_W-1:0]   index;
    } bin_report_t;

    logic signed [EDGE_W-1:0] lo_edge;
    logic signed [EDGE_W-1:0] hi_edge;
    logic [NBINS_W-1:0]       bins_in_use;
    logic [INV_W-1:0]         inv_width;
    logic [COUNT_W-1:0]       bin_counts [MAX_BINS];
    bin_report_t              expected_reads [$];
    int                       mismatches;
    logic [BIN_W-1:0]         sel;
    bin_report_t              got;
    bin_report_t              want;

    // Adds one sample to the mirrored counts, following the block's binning rules.
    function automatic void count_sample(logic signed [SAMPLE_W-1:0] v);
        logic [NBINS_W-1:0] nb;
        logic [63:0]        diff;
        logic [63:0]        prod;
        logic [31:0]        slot;
        logic [31:0]        last_bin;
        nb = bins_in_use;
        if (nb == '0)
            nb = NBINS_W'(1);
        if (nb > NBINS_W'(MAX_BINS))
            nb = NBINS_W'(MAX_BINS);
        last_bin = 32'(nb) - 32'd1;
        if (v >= lo_edge && v < hi_edge)
        begin
            diff = longint'(v) - longint'(lo_edge);
            prod = diff * {32'd0, inv_width};
            slot = prod[63:32];
            if (slot > last_bin)
                slot = last_bin;
        end
        else if (v == hi_edge)
            slot = last_bin;
        else
            return;
        if (bin_counts[slot[BIN_W-1:0]] != '1)
            bin_counts[slot[BIN_W-1:0]] = bin_counts[slot[BIN_W-1:0]] + COUNT_W'(1);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lo_edge     = '0;
            hi_edge     = 32'sd16777216;
            bins_in_use = 9'd256;
            inv_width   = 32'd65536;
            foreach (bin_counts[i])
                bin_counts[i] = '0;
            expected_reads.delete();
            mismatches = 0;
            mismatch_total <= 0;
            reads_waiting  <= 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                case (cfg_idx_t'(paddr[3:2]))
                    REG_EDGE_MIN:  lo_edge     = pwdata[EDGE_W-1:0];
                    REG_EDGE_MAX:  hi_edge     = pwdata[EDGE_W-1:0];
                    REG_NUM_BINS:  bins_in_use = pwdata[NBINS_W-1:0];
                    REG_INV_WIDTH: inv_width   = pwdata[INV_W-1:0];
                    default: ;
                endcase
            end

            if (s_tvalid && s_tready)
            begin
                if (req_t'(s_tuser) == REQ_ADD)
                    count_sample(s_tdata[SAMPLE_W-1:0]);
                else
                begin
                    sel = s_tdata[SAMPLE_W +: BIN_W];
                    want.count = bin_counts[sel];
                    want.index = sel;
                    expected_reads.push_back(want);
                    bin_counts[sel] = '0;
                end
            end

            if (m_tvalid && m_tready)
            begin
                got.count = m_tdata[COUNT_W-1:0];
                got.index = m_tdata[COUNT_W +: BIN_W];
                if (expected_reads.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: result beat with nothing expected: count %0d bin %0d",
                                 $realtime, got.count, got.index);
                end
                else
                begin
                    want = expected_reads.pop_front();
                    if (got.count !== want.count || got.index !== want.index)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("%0t: mismatch: bin_count exp %0d got %0d, bin_index exp %0d got %0d",
                                     $realtime, want.count, got.count, want.index, got.index);
                    end
                end
            end

            reads_waiting  <= expected_reads.size();
            mismatch_total <= mismatches;
        end
    end

endmodule

[tb/testbench.sv]
// Top of the histogram testbench: clock, reset, register setup, request stimulus and verdict.
// Depends on ubh_pkg, uniform_bin_histogram_unit and uniform_bin_histogram_checker.
`timescale 1ns / 1ps

module testbench;
    import ubh_pkg::*;

    localparam int CYCLE_LIMIT  = 1000000;
    localparam int SETTLE       = 8;
    localparam int HOLD_CYCLES  = 300;
    localparam int PHASE_ITEMS  = 110;
    localparam int PHASES       = 12;

    logic                  clk;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata;
    logic                  s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OUT_DATA_W-1:0] m_tdata;

    int mismatch_total;
    int reads_waiting;
    int cycles;
    int items_sent;
    bit src_steady;

    logic signed [31:0] lo_e;
    logic signed [31:0] hi_e;
    int                 nb_eff;

    uniform_bin_histogram_unit dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    uniform_bin_histogram_checker chk (
        .clk            (clk),
        .rst_n          (rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .pready         (pready),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tuser        (s_tuser),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .mismatch_total (mismatch_total),
        .reads_waiting  (reads_waiting)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 96)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Reciprocal programmed into the inverse-width register: num_bins / (edge_max - edge_min) in Q0.32.
    function automatic logic [31:0] exact_inv(logic signed [31:0] lo, logic signed [31:0] hi,
                                              int nb);
        longint      span;
        logic [63:0] q;
        span = longint'(hi) - longint'(lo);
        if (span <= 0)
            return '1;
        q = (64'(nb) << 32) / 64'(span);
        if (q > 64'hFFFF_FFFF)
            return '1;
        return q[31:0];
    endfunction

    task automatic write_reg(cfg_idx_t idx, logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    task automatic program_bins(logic signed [31:0] lo, logic signed [31:0] hi, int nb,
                                logic [31:0] inv);
        write_reg(REG_EDGE_MIN, lo);
        write_reg(REG_EDGE_MAX, hi);
        write_reg(REG_NUM_BINS, nb);
        write_reg(REG_INV_WIDTH, inv);
        lo_e   = lo;
        hi_e   = hi;
        nb_eff = (nb == 0) ? 1 : (nb > MAX_BINS) ? MAX_BINS : nb;
    endtask

    task automatic send_item(req_t kind, logic [31:0] sample, logic [7:0] sel);
        int gap;
        s_tvalid <= 1'b1;
        s_tdata  <= {sel, sample};
        s_tuser  <= kind;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        items_sent++;
        gap = src_steady ? 0 : pick_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Stops offering beats and waits until every read result is back and adds have retired.
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (reads_waiting != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic pick_edges(output logic signed [31:0] lo, output logic signed [31:0] hi);
        longint top;
        lo = $urandom();
        case ($urandom_range(0, 2))
            0:       top = longint'(lo) + $urandom_range(1, 4096);
            1:       top = longint'(lo) + $urandom_range(1, 1 << 24);
            default: top = longint'(lo) + longint'($urandom());
        endcase
        if (top > 64'sh7FFF_FFFF)
            top = 64'sh7FFF_FFFF;
        hi = top[31:0];
    endtask

    // Most samples land inside the range; the rest sit on the edges or anywhere.
    function automatic logic [31:0] next_sample();
        longint      span;
        logic [63:0] off;
        int          r;
        span = longint'(hi_e) - longint'(lo_e);
        r = $urandom_range(0, 99);
        if (r < 60 && span > 0)
        begin
            off = {$urandom(), $urandom()} % 64'(span);
            return 32'(longint'(lo_e) + longint'(off));
        end
        if (r < 66)
            return lo_e;
        if (r < 72)
            return hi_e;
        if (r < 76)
            return hi_e - 1;
        if (r < 80)
            return lo_e - 1;
        if (r < 86)
        begin
            case ($urandom_range(0, 3))
                0:       return 32'h8000_0000;
                1:       return 32'h7FFF_FFFF;
                2:       return 32'h0000_0000;
                default: return 32'hFFFF_FFFF;
            endcase
        end
        return $urandom();
    endfunction

    task automatic random_phase(int kind);
        logic signed [31:0] lo;
        logic signed [31:0] hi;
        logic signed [31:0] tmp;
        int                 nb;
        logic [31:0]        inv;
        pick_edges(lo, hi);
        nb = $urandom_range(1, MAX_BINS);
        inv = exact_inv(lo, hi, nb);
        case (kind)
            1:
            begin
                nb = 1;
                inv = '0;
            end
            2:
            begin
                lo = 32'sh8000_0000;
                hi = 32'sh7FFF_FFFF;
                nb = MAX_BINS;
                inv = exact_inv(lo, hi, nb);
            end
            3:
            begin
                nb = 0;
                inv = $urandom();
            end
            4:
            begin
                nb = $urandom_range(MAX_BINS + 1, 511);
                inv = $urandom_range(0, 1) ? exact_inv(lo, hi, MAX_BINS) : $urandom();
            end
            5:
            begin
                tmp = lo;
                lo = hi;
                hi = tmp;
                inv = $urandom();
            end
            6:
            begin
                hi = lo;
                inv = $urandom();
            end
            7: inv = $urandom_range(0, 1) ? 32'hFFFF_FFFF : $urandom();
            default: ;
        endcase
        wait_idle();
        program_bins(lo, hi, nb, inv);
        src_steady = ($urandom_range(0, 3) == 0);
        repeat (PHASE_ITEMS)
        begin
            if ($urandom_range(0, 3) == 0)
                send_item(REQ_READ, $urandom(),
                          ($urandom_range(0, 9) < 7) ? 8'($urandom_range(0, nb_eff - 1))
                                                     : 8'($urandom_range(0, 255)));
            else
                send_item(REQ_ADD, next_sample(), 8'($urandom()));
        end
    endtask

    // Result side: random stalls, stretches of steady ready, and one long hold-off
    // that fills the block while the request side keeps offering beats.
    initial
    begin
        bit held;
        bit steady;
        int gap;
        held = 1'b0;
        steady = 1'b0;
        m_tready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            if ($urandom_range(0, 49) == 0)
                steady = !steady;
            if (!held && items_sent >= 150)
            begin
                held = 1'b1;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else if (steady)
            begin
                m_tready <= 1'b1;
                @(posedge clk);
            end
            else
            begin
                gap = pick_gap();
                if (gap > 0)
                begin
                    m_tready <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
                m_tready <= 1'b1;
                repeat ($urandom_range(1, 4)) @(posedge clk);
            end
        end
    end

    initial
    begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("testbench: errors");
        $finish;
    end

    initial
    begin
        rst_n    <= 1'b0;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= REQ_ADD;
        items_sent = 0;
        src_steady = 1'b0;
        lo_e   = '0;
        hi_e   = 32'sd16777216;
        nb_eff = MAX_BINS;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: bins of width 1.0 over [0, 256.0].
        send_item(REQ_ADD, 32'h0000_0000, 8'h00);
        send_item(REQ_ADD, 32'h0100_0000, 8'hFF);
        send_item(REQ_ADD, 32'h00FF_FFFF, 8'h00);
        send_item(REQ_ADD, 32'hFFFF_FFFF, 8'hFF);
        send_item(REQ_ADD, 32'h7FFF_FFFF, 8'h00);
        send_item(REQ_ADD, 32'h8000_0000, 8'hFF);
        send_item(REQ_ADD, 32'h0001_8000, 8'h00);
        send_item(REQ_READ, 32'hFFFF_FFFF, 8'h00);
        send_item(REQ_READ, 32'h0000_0000, 8'hFF);
        send_item(REQ_READ, 32'hA5A5_5A5A, 8'h01);
        send_item(REQ_READ, 32'h5A5A_A5A5, 8'h00);

        // Widest possible range split into four bins.
        wait_idle();
        program_bins(32'sh8000_0000, 32'sh7FFF_FFFF, 4,
                     exact_inv(32'sh8000_0000, 32'sh7FFF_FFFF, 4));
        send_item(REQ_ADD, 32'h8000_0000, 8'h00);
        send_item(REQ_ADD, 32'h7FFF_FFFF, 8'h00);
        send_item(REQ_ADD, 32'h7FFF_FFFE, 8'h00);
        send_item(REQ_ADD, 32'h0000_0000, 8'h00);
        send_item(REQ_READ, 32'h0, 8'd0);
        send_item(REQ_READ, 32'h0, 8'd1);
        send_item(REQ_READ, 32'h0, 8'd2);
        send_item(REQ_READ, 32'h0, 8'd3);

        for (int p = 0; p < PHASES; p++)
            random_phase(p % 8);

        wait_idle();
        if (mismatch_total == 0 && reads_waiting == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

endmodule
